### hw/rtl/rdrv_pkg.sv
// ----------------------------------------------------------------------------
// Radar detection range and velocity package
// Shared widths, register codes, word types and the divider step functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rdrv_pkg;

   localparam int FRAC_W  = 16;
   localparam int MAG_W   = 31;
   localparam int RBIN_W  = 10;
   localparam int DBIN_W  = 8;
   localparam int DATA_W  = 32;
   localparam int NRB_W   = 11;
   localparam int NDB_W   = 9;
   localparam int RES_W   = 31;
   localparam int ADDR_W  = 4;

   localparam int NUM_W   = MAG_W + FRAC_W;
   localparam int D2_W    = NUM_W + 1;
   localparam int REM_W   = D2_W + 1;
   localparam int Q_W     = FRAC_W + 1;
   localparam int IDX_W   = RBIN_W + FRAC_W + 1;
   localparam int DPROD_W = IDX_W + RES_W;
   localparam int VEL_W   = NDB_W + 1;
   localparam int VPROD_W = VEL_W + RES_W + 1;

   localparam int DIV1_STEPS = NUM_W;
   localparam int DIV2_STEPS = FRAC_W + 1;
   localparam int NUM_STAGES = DIV1_STEPS + DIV2_STEPS + 2;

   localparam logic [NRB_W-1:0] MAX_RANGE_BINS   = NRB_W'(1024);
   localparam logic [NDB_W-1:0] MAX_DOPPLER_BINS = NDB_W'(256);
   localparam logic [RES_W-1:0] RES_RESET        = RES_W'(1);

   localparam logic [1:0] REG_NUM_RANGE_BINS      = 2'd0;
   localparam logic [1:0] REG_NUM_DOPPLER_BINS    = 2'd1;
   localparam logic [1:0] REG_RANGE_RESOLUTION    = 2'd2;
   localparam logic [1:0] REG_VELOCITY_RESOLUTION = 2'd3;

   typedef struct packed {
      logic [RBIN_W-1:0]        range_bin;
      logic [DBIN_W-1:0]        doppler_bin;
      logic [MAG_W-1:0]         mag_below;
      logic [MAG_W-1:0]         mag_peak;
      logic [MAG_W-1:0]         mag_above;
      logic signed [DATA_W-1:0] amplitude;
      logic signed [DATA_W-1:0] signal_noise;
      logic                     last_point;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] distance;
      logic signed [DATA_W-1:0] velocity;
      logic signed [DATA_W-1:0] amplitude_out;
      logic signed [DATA_W-1:0] signal_noise_out;
      logic                     distance_overflow;
      logic                     velocity_overflow;
      logic                     last_result;
   } rsp_type;

   typedef struct packed {
      logic [RBIN_W-1:0]         bin;
      logic                      neg;
      logic                      pos;
      logic [DBIN_W-1:0]         dop;
      logic signed [DATA_W-1:0]  amp;
      logic signed [DATA_W-1:0]  snr;
      logic                      last;
      logic [MAG_W-1:0]          numer;
      logic [MAG_W-1:0]          denom;
      logic [D2_W-1:0]           d2;
      logic [REM_W-1:0]          rem;
      logic [NUM_W-1:0]          quot;
      logic [DPROD_W-1:0]        dist_prod;
      logic signed [VPROD_W-1:0] vel_prod;
   } pipe_type;

   // One quotient bit of the numer / denom ratio, which is peak to neighbor except at range bin 0.
   function automatic pipe_type div1_step(pipe_type s);
      pipe_type         r;
      logic [MAG_W:0]   t;
      logic [MAG_W:0]   diff;
      r = s;
      t = {s.rem[MAG_W-1:0], s.numer[MAG_W-1]};
      diff = t - {1'b0, s.denom};
      r.numer = s.numer << 1;
      if (t >= {1'b0, s.denom}) begin
         r.rem  = REM_W'(diff[MAG_W-1:0]);
         r.quot = {s.quot[NUM_W-2:0], 1'b1};
      end else begin
         r.rem  = REM_W'(t[MAG_W-1:0]);
         r.quot = {s.quot[NUM_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // One quotient bit of the fraction 2^(2F) / (ratio + 2^F).
   function automatic pipe_type div2_step(pipe_type s, logic first);
      pipe_type         r;
      logic [D2_W-1:0]  d;
      logic [REM_W-1:0] rm;
      logic [NUM_W-1:0] q;
      logic [REM_W-1:0] t;
      r = s;
      if (first) begin
         d  = D2_W'(s.quot) + (D2_W'(1) << FRAC_W);
         rm = REM_W'(1) << (FRAC_W - 1);
         q  = '0;
      end else begin
         d  = s.d2;
         rm = s.rem;
         q  = s.quot;
      end
      t = {rm[REM_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
         rm = t - {1'b0, d};
         q  = {q[NUM_W-2:0], 1'b1};
      end else begin
         rm = t;
         q  = {q[NUM_W-2:0], 1'b0};
      end
      r.d2   = d;
      r.rem  = rm;
      r.quot = q;
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/radar_detection_range_velocity_unit.sv
// ----------------------------------------------------------------------------
// Radar detection range and velocity unit
// Converts detections into interpolated distance and signed velocity words.
// ----------------------------------------------------------------------------
// Throughput is one word per cycle while the skid buffer is not full, set by the
// bit-per-stage divider pipelines (47 stages for the ratio, 17 for the fraction)
// and one multiply stage.
// A two-entry output register and skid buffer decouple the two channels.
// Synchronous reset clears all valid bits and restores register defaults.
`default_nettype none

module radar_detection_range_velocity_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire rdrv_pkg::req_type           req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output rdrv_pkg::rsp_type                rsp_data,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [rdrv_pkg::ADDR_W-1:0] paddr,
   input  wire logic [rdrv_pkg::DATA_W-1:0] pwdata,
   output logic [rdrv_pkg::DATA_W-1:0]      prdata,
   output logic                             pready
);

   localparam int NS   = rdrv_pkg::NUM_STAGES;
   localparam int D1   = rdrv_pkg::DIV1_STEPS;
   localparam int D2   = rdrv_pkg::DIV2_STEPS;
   localparam int VPW  = rdrv_pkg::VPROD_W;
   localparam logic [rdrv_pkg::DATA_W-1:0] I32_MAX = 32'h7fff_ffff;
   localparam logic signed [VPW-1:0] VEL_MAX = VPW'(I32_MAX);
   localparam logic signed [VPW-1:0] VEL_MIN = -VEL_MAX;

   logic [rdrv_pkg::NRB_W-1:0] nrb_ff;
   logic [rdrv_pkg::NDB_W-1:0] ndb_ff;
   logic [rdrv_pkg::RES_W-1:0] rres_ff;
   logic [rdrv_pkg::RES_W-1:0] vres_ff;
   logic                       cfg_wr;

   rdrv_pkg::pipe_type stage_ff [NS];
   rdrv_pkg::pipe_type stage_in [NS];
   logic [NS-1:0]      valid_ff;
   logic               adv;

   rdrv_pkg::rsp_type  out_ff;
   rdrv_pkg::rsp_type  skid_ff;
   rdrv_pkg::rsp_type  done;
   logic               out_valid_ff;
   logic               skid_full_ff;

   // Configuration registers.
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         nrb_ff  <= rdrv_pkg::MAX_RANGE_BINS;
         ndb_ff  <= rdrv_pkg::MAX_DOPPLER_BINS;
         rres_ff <= rdrv_pkg::RES_RESET;
         vres_ff <= rdrv_pkg::RES_RESET;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            rdrv_pkg::REG_NUM_RANGE_BINS:      nrb_ff  <= pwdata[rdrv_pkg::NRB_W-1:0];
            rdrv_pkg::REG_NUM_DOPPLER_BINS:    ndb_ff  <= pwdata[rdrv_pkg::NDB_W-1:0];
            rdrv_pkg::REG_RANGE_RESOLUTION:    rres_ff <= pwdata[rdrv_pkg::RES_W-1:0];
            rdrv_pkg::REG_VELOCITY_RESOLUTION: vres_ff <= pwdata[rdrv_pkg::RES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         rdrv_pkg::REG_NUM_RANGE_BINS:      prdata = rdrv_pkg::DATA_W'(nrb_ff);
         rdrv_pkg::REG_NUM_DOPPLER_BINS:    prdata = rdrv_pkg::DATA_W'(ndb_ff);
         rdrv_pkg::REG_RANGE_RESOLUTION:    prdata = rdrv_pkg::DATA_W'(rres_ff);
         rdrv_pkg::REG_VELOCITY_RESOLUTION: prdata = rdrv_pkg::DATA_W'(vres_ff);
         default:                           prdata = '0;
      endcase
   end

   assign adv       = ~skid_full_ff;
   assign req_ready = adv;

   // Neighbor choice and divider setup.
   always_comb begin
      rdrv_pkg::pipe_type s;
      logic [rdrv_pkg::MAG_W-1:0] dn;
      s       = '0;
      s.dop   = req_data.doppler_bin;
      s.amp   = req_data.amplitude;
      s.snr   = req_data.signal_noise;
      s.last  = req_data.last_point;
      s.bin   = req_data.range_bin;
      s.numer = req_data.mag_peak;
      if (req_data.range_bin == '0) begin
         s.bin   = rdrv_pkg::RBIN_W'(1);
         s.neg   = 1'b1;
         s.numer = req_data.mag_above;
         dn      = req_data.mag_peak;
      end else if ((rdrv_pkg::NRB_W'(req_data.range_bin) + rdrv_pkg::NRB_W'(1) >= nrb_ff)
                   || (req_data.mag_below > req_data.mag_above)) begin
         s.neg = 1'b1;
         dn    = req_data.mag_below;
      end else if (req_data.mag_below < req_data.mag_above) begin
         s.pos = 1'b1;
         dn    = req_data.mag_above;
      end else begin
         dn    = req_data.mag_peak;
      end
      if (dn == '0) begin
         s.neg = 1'b0;
         s.pos = 1'b0;
         dn    = rdrv_pkg::MAG_W'(1);
      end
      s.denom     = dn;
      stage_in[0] = s;
   end

   for (genvar g = 1; g < NS; g++) begin : g_stage
      if (g <= D1) begin : g_div1
         assign stage_in[g] = rdrv_pkg::div1_step(stage_ff[g-1]);
      end else if (g <= D1 + D2) begin : g_div2
         assign stage_in[g] = rdrv_pkg::div2_step(stage_ff[g-1], (g == D1 + 1));
      end else begin : g_mult
         always_comb begin
            rdrv_pkg::pipe_type s;
            logic [rdrv_pkg::IDX_W-1:0] base;
            logic [rdrv_pkg::IDX_W-1:0] idx;
            logic [rdrv_pkg::IDX_W-1:0] q;
            logic signed [rdrv_pkg::VEL_W-1:0] ds;
            s    = stage_ff[g-1];
            q    = rdrv_pkg::IDX_W'(s.quot[rdrv_pkg::Q_W-1:0]);
            base = rdrv_pkg::IDX_W'(s.bin) << rdrv_pkg::FRAC_W;
            if (s.pos) begin
               idx = base + q;
            end else if (s.neg) begin
               idx = base - q;
            end else begin
               idx = base;
            end
            s.dist_prod = rdrv_pkg::DPROD_W'(idx) * rdrv_pkg::DPROD_W'(rres_ff);
            if (rdrv_pkg::NDB_W'(s.dop) >= (ndb_ff >> 1)) begin
               ds = $signed(rdrv_pkg::VEL_W'(s.dop)) - $signed(rdrv_pkg::VEL_W'(ndb_ff));
            end else begin
               ds = $signed(rdrv_pkg::VEL_W'(s.dop));
            end
            s.vel_prod  = VPW'(ds) * VPW'($signed({1'b0, vres_ff}));
            stage_in[g] = s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NS; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NS-2:0], req_valid};
      end
   end

   // Saturation and response word assembly.
   always_comb begin
      logic [rdrv_pkg::DPROD_W-1:0] dsh;
      dsh = stage_ff[NS-1].dist_prod >> rdrv_pkg::FRAC_W;
      done.amplitude_out     = stage_ff[NS-1].amp;
      done.signal_noise_out  = stage_ff[NS-1].snr;
      done.last_result       = stage_ff[NS-1].last;
      done.distance_overflow = dsh > rdrv_pkg::DPROD_W'(I32_MAX);
      done.distance = done.distance_overflow ? $signed(I32_MAX)
                                             : $signed(dsh[rdrv_pkg::DATA_W-1:0]);
      done.velocity_overflow = (stage_ff[NS-1].vel_prod > VEL_MAX)
                               || (stage_ff[NS-1].vel_prod < VEL_MIN);
      done.velocity = done.velocity_overflow ? $signed(I32_MAX)
                      : $signed(stage_ff[NS-1].vel_prod[rdrv_pkg::DATA_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (adv && valid_ff[NS-1]) begin
         if (!out_valid_ff || rsp_ready) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_full_ff <= 1'b1;
         end
      end else if (skid_full_ff) begin
         if (rsp_ready) begin
            skid_full_ff <= 1'b0;
         end
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && valid_ff[NS-1]) begin
         if (!out_valid_ff || rsp_ready) begin
            out_ff <= done;
         end else begin
            skid_ff <= done;
         end
      end else if (skid_full_ff && rsp_ready) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire
